### hw/rtl/wbm_pkg.sv
// ----------------------------------------------------------------------------
// wbm_pkg
// Shared types and constants of the weighted bipartite matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wbm_pkg;

  localparam int unsigned SizeW  = 5;   // width of the size register
  localparam int unsigned RowW   = 4;   // width of reported row/column codes
  localparam int unsigned PaddrW = 3;   // byte address width of the config port
  localparam int unsigned PdataW = 32;

  // Register select taken from paddr[2]
  localparam logic RegSizeInUse = 1'b0;

  typedef struct packed {
    logic [SizeW-1:0] size;     // value last written
    logic             dflt;     // no write since reset: use the full size
    logic             restart;  // one-cycle pulse on a size write
  } cfg_t;

endpackage

`default_nettype wire

### hw/rtl/wbm_wstore.sv
// ----------------------------------------------------------------------------
// wbm_wstore
// Weight memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_wstore #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/wbm_cfg.sv
// ----------------------------------------------------------------------------
// wbm_cfg
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_cfg #(
  parameter int unsigned MAX_SIZE = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [wbm_pkg::PaddrW-1:0]   paddr,
  input  wire logic [wbm_pkg::PdataW-1:0]   pwdata,
  output logic      [wbm_pkg::PdataW-1:0]   prdata,
  output logic                              pready,
  output wbm_pkg::cfg_t                     cfg_o
);

  localparam logic [wbm_pkg::SizeW-1:0] DfltSize =
    (MAX_SIZE > 31) ? wbm_pkg::SizeW'(31) : wbm_pkg::SizeW'(MAX_SIZE);

  logic                       wr_size;
  logic [wbm_pkg::SizeW-1:0]  size_q;
  logic                       dflt_q;

  assign pready  = 1'b1;
  assign wr_size = psel && penable && pwrite && (paddr[2] == wbm_pkg::RegSizeInUse);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= '0;
      dflt_q    <= 1'b1;
    end else begin
      if (wr_size) begin
        size_q <= pwdata[wbm_pkg::SizeW-1:0];
        dflt_q <= 1'b0;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == wbm_pkg::RegSizeInUse) begin
      prdata[wbm_pkg::SizeW-1:0] = dflt_q ? DfltSize : size_q;
    end
  end

  // Restart reaches the loader in the same cycle as the write.
  assign cfg_o.size    = wr_size ? pwdata[wbm_pkg::SizeW-1:0] : size_q;
  assign cfg_o.dflt    = wr_size ? 1'b0 : dflt_q;
  assign cfg_o.restart = wr_size;

endmodule

`default_nettype wire

### hw/rtl/weighted_bipartite_matcher.sv
// ----------------------------------------------------------------------------
// weighted_bipartite_matcher
// Maximum-weight perfect assignment (Kuhn-Munkres) over an n x n matrix of
// signed fixed-point weights loaded one per transfer in row-major order.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, weight_i                | sink
//  out     | out_valid_o, out_ready_i, row_index_o,          | source
//          | matched_column_o, last_o                        |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata,   | APB slave
//          | pready                                          |
//
//  Load: n*n weights, one per cycle while in_valid_i is high, into the weight memory;
//  in_ready_o low otherwise. Match: a row-maximum pass (read, write per weight); per search
//  a prepare step, a scan past each column already reached, a read, gap and test of each
//  other column, stack pops and unwinds, and a minimum-slack pass with its label move.
//  Emit: one row per cycle, while out_ready_i is high, via the output register; loading of
//  the next matrix opens while the last row still waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_bipartite_matcher #(
  parameter int unsigned MAX_SIZE    = 16,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // weight input
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [31:0]            weight_i,
  // assignment results
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [wbm_pkg::RowW-1:0]           row_index_o,
  output logic [wbm_pkg::RowW-1:0]           matched_column_o,
  output logic                               last_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wbm_pkg::PaddrW-1:0]    paddr,
  input  wire logic [wbm_pkg::PdataW-1:0]    pwdata,
  output logic      [wbm_pkg::PdataW-1:0]    prdata,
  output logic                               pready
);

  localparam int unsigned IW    = $clog2(MAX_SIZE);        // row/column index
  localparam int unsigned NW    = $clog2(MAX_SIZE + 1);    // count up to n
  localparam int unsigned DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LB    = WEIGHT_BITS + 8;         // label width
  localparam int unsigned GW    = LB + 2;                  // gap / slack width

  typedef enum logic [3:0] {
    S_LOAD, S_INIT_RD, S_INIT_WR, S_PREP, S_SCAN, S_EVAL, S_CHECK,
    S_UNWIND, S_MIN, S_ADJ, S_OUT
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration and effective size
  // --------------------------------------------------------------------------
  wbm_pkg::cfg_t cfg;

  wbm_cfg #(.MAX_SIZE(MAX_SIZE)) u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  logic [NW-1:0] n;      // effective size, 1..MAX_SIZE
  logic [IW-1:0] n_m1;   // last valid index

  always_comb begin
    if (cfg.dflt || (32'(cfg.size) > MAX_SIZE)) begin
      n = NW'(MAX_SIZE);
    end else if (cfg.size == '0) begin
      n = NW'(1);
    end else begin
      n = NW'(cfg.size);
    end
    n_m1 = IW'(n - NW'(1));
  end

  // --------------------------------------------------------------------------
  // Weight saturation to the stored width
  // --------------------------------------------------------------------------
  logic signed [WEIGHT_BITS-1:0] w_sat;

  if (WEIGHT_BITS >= 32) begin : g_wide
    assign w_sat = WEIGHT_BITS'(weight_i);
  end else begin : g_narrow
    logic fits;
    assign fits = (weight_i[31:WEIGHT_BITS-1] == '0) || (weight_i[31:WEIGHT_BITS-1] == '1);
    always_comb begin
      if (fits) begin
        w_sat = weight_i[WEIGHT_BITS-1:0];
      end else if (weight_i[31]) begin
        w_sat = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
      end else begin
        w_sat = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
      end
    end
  end

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_e              state_q;
  logic [IW-1:0]       ld_row_q, ld_col_q;
  logic [IW-1:0]       ir_q, ic_q;                  // row-max pass / min pass index
  logic signed [LB-1:0] rmax_q;
  logic [IW-1:0]       x_q;                         // row being matched
  logic [IW-1:0]       cur_r_q;
  logic [NW-1:0]       cur_c_q;
  logic [IW-1:0]       sp_q;
  logic [IW-1:0]       stk_r_q [MAX_SIZE];
  logic [IW-1:0]       stk_c_q [MAX_SIZE];
  logic signed [LB-1:0] row_lbl_q [MAX_SIZE];
  logic signed [LB-1:0] col_lbl_q [MAX_SIZE];
  logic [IW-1:0]       row_ptr_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] row_ptr_v_q;
  logic [IW-1:0]       col_ptr_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] col_ptr_v_q;
  logic [MAX_SIZE-1:0] row_vis_q, col_vis_q;
  logic [GW-1:0]       slack_q [MAX_SIZE];
  logic [MAX_SIZE-1:0] slack_v_q;
  logic [GW-1:0]       mn_q;
  logic                mn_v_q;
  logic signed [GW-1:0] gap_q, ngap_q;
  logic                out_valid_q;
  logic [wbm_pkg::RowW-1:0] out_row_q, out_col_q;
  logic                out_last_q;

  // --------------------------------------------------------------------------
  // Weight memory
  // --------------------------------------------------------------------------
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic signed [WEIGHT_BITS-1:0] mem_rdata;
  logic [IW-1:0]                 cc;   // current column as an index

  assign cc        = cur_c_q[IW-1:0];
  assign in_ready_o = (state_q == S_LOAD);
  assign mem_we    = in_valid_i && in_ready_o && !cfg.restart;
  assign mem_waddr = AW'(ld_row_q) * AW'(MAX_SIZE) + AW'(ld_col_q);
  assign mem_raddr = (state_q == S_SCAN) ? AW'(cur_r_q) * AW'(MAX_SIZE) + AW'(cc)
                                         : AW'(ir_q) * AW'(MAX_SIZE) + AW'(ic_q);

  wbm_wstore #(.DEPTH(DEPTH), .DATA_W(WEIGHT_BITS)) u_wstore (
    .clk_i,
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(w_sat),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic signed [LB-1:0] rd_w;
  logic signed [LB-1:0] rmax_d;
  logic [GW-1:0]        abs_gap;
  logic                 mn_take;

  assign rd_w    = LB'(mem_rdata);
  assign rmax_d  = ((ic_q == '0) || (rd_w > rmax_q)) ? rd_w : rmax_q;
  assign abs_gap = gap_q[GW-1] ? ngap_q : gap_q;
  assign mn_take = !col_vis_q[ic_q] && slack_v_q[ic_q] &&
                   (!mn_v_q || (slack_q[ic_q] < mn_q));

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      ld_row_q    <= '0;
      ld_col_q    <= '0;
      ir_q        <= '0;
      ic_q        <= '0;
      rmax_q      <= '0;
      x_q         <= '0;
      cur_r_q     <= '0;
      cur_c_q     <= '0;
      sp_q        <= '0;
      row_ptr_v_q <= '0;
      col_ptr_v_q <= '0;
      row_vis_q   <= '0;
      col_vis_q   <= '0;
      slack_v_q   <= '0;
      mn_q        <= '0;
      mn_v_q      <= 1'b0;
      gap_q       <= '0;
      ngap_q      <= '0;
      out_valid_q <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b0;
      for (int k = 0; k < MAX_SIZE; k++) begin
        stk_r_q[k]   <= '0;
        stk_c_q[k]   <= '0;
        row_lbl_q[k] <= '0;
        col_lbl_q[k] <= '0;
        row_ptr_q[k] <= '0;
        col_ptr_q[k] <= '0;
        slack_q[k]   <= '0;
      end
    end else begin
      // Drop a taken result unless the emit state refills the register.
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.restart) begin
        ld_row_q <= '0;
        ld_col_q <= '0;
      end

      unique case (state_q)
        S_LOAD: begin
          if (mem_we) begin
            if (ld_col_q == n_m1) begin
              ld_col_q <= '0;
              if (ld_row_q == n_m1) begin
                // Last weight: open the matching run.
                ld_row_q    <= '0;
                ir_q        <= '0;
                ic_q        <= '0;
                row_ptr_v_q <= '0;
                col_ptr_v_q <= '0;
                for (int k = 0; k < MAX_SIZE; k++) begin
                  col_lbl_q[k] <= '0;
                end
                state_q <= S_INIT_RD;
              end else begin
                ld_row_q <= ld_row_q + IW'(1);
              end
            end else begin
              ld_col_q <= ld_col_q + IW'(1);
            end
          end
        end

        S_INIT_RD: begin
          state_q <= S_INIT_WR;
        end

        S_INIT_WR: begin
          rmax_q  <= rmax_d;
          state_q <= S_INIT_RD;
          if (ic_q == n_m1) begin
            row_lbl_q[ir_q] <= rmax_d;
            ic_q            <= '0;
            if (ir_q == n_m1) begin
              x_q     <= '0;
              state_q <= S_PREP;
            end else begin
              ir_q <= ir_q + IW'(1);
            end
          end else begin
            ic_q <= ic_q + IW'(1);
          end
        end

        S_PREP: begin
          row_vis_q       <= {{(MAX_SIZE-1){1'b0}}, 1'b1} << x_q;
          col_vis_q       <= '0;
          slack_v_q       <= '0;
          cur_r_q         <= x_q;
          cur_c_q         <= '0;
          sp_q            <= '0;
          state_q         <= S_SCAN;
        end

        S_SCAN: begin
          if (cur_c_q >= n) begin
            if (sp_q == '0) begin
              // Search exhausted: look for the smallest slack.
              ic_q    <= '0;
              mn_v_q  <= 1'b0;
              state_q <= S_MIN;
            end else begin
              cur_r_q <= stk_r_q[sp_q - IW'(1)];
              cur_c_q <= NW'(stk_c_q[sp_q - IW'(1)]) + NW'(1);
              sp_q    <= sp_q - IW'(1);
            end
          end else if (col_vis_q[cc]) begin
            cur_c_q <= cur_c_q + NW'(1);
          end else begin
            state_q <= S_EVAL;
          end
        end

        S_EVAL: begin
          gap_q  <= GW'(row_lbl_q[cur_r_q]) + GW'(col_lbl_q[cc]) - GW'(rd_w);
          ngap_q <= GW'(rd_w) - GW'(row_lbl_q[cur_r_q]) - GW'(col_lbl_q[cc]);
          state_q <= S_CHECK;
        end

        S_CHECK: begin
          state_q <= S_SCAN;
          if (gap_q == '0) begin
            col_vis_q[cc] <= 1'b1;
            if (!col_ptr_v_q[cc]) begin
              state_q <= S_UNWIND;
            end else if (32'(sp_q) < MAX_SIZE - 1) begin
              // Descend into the row that holds this column.
              stk_r_q[sp_q]               <= cur_r_q;
              stk_c_q[sp_q]               <= cc;
              sp_q                        <= sp_q + IW'(1);
              cur_r_q                     <= col_ptr_q[cc];
              cur_c_q                     <= '0;
              row_vis_q[col_ptr_q[cc]]    <= 1'b1;
            end else begin
              cur_c_q <= cur_c_q + NW'(1);
            end
          end else begin
            if (!slack_v_q[cc] || (abs_gap < slack_q[cc])) begin
              slack_q[cc]   <= abs_gap;
              slack_v_q[cc] <= 1'b1;
            end
            cur_c_q <= cur_c_q + NW'(1);
          end
        end

        S_UNWIND: begin
          // Flip the path one edge a cycle, top of stack first.
          col_ptr_q[cc]        <= cur_r_q;
          col_ptr_v_q[cc]      <= 1'b1;
          row_ptr_q[cur_r_q]   <= cc;
          row_ptr_v_q[cur_r_q] <= 1'b1;
          if (sp_q == '0) begin
            if (x_q == n_m1) begin
              ir_q    <= '0;
              state_q <= S_OUT;
            end else begin
              x_q     <= x_q + IW'(1);
              state_q <= S_PREP;
            end
          end else begin
            cur_r_q <= stk_r_q[sp_q - IW'(1)];
            cur_c_q <= NW'(stk_c_q[sp_q - IW'(1)]);
            sp_q    <= sp_q - IW'(1);
          end
        end

        S_MIN: begin
          if (mn_take) begin
            mn_q   <= slack_q[ic_q];
            mn_v_q <= 1'b1;
          end
          ic_q <= ic_q + IW'(1);
          if (ic_q == n_m1) begin
            if (mn_take || mn_v_q) begin
              state_q <= S_ADJ;
            end else if (x_q == n_m1) begin
              // Row left unmatched: drop it and move on.
              ir_q    <= '0;
              state_q <= S_OUT;
            end else begin
              x_q     <= x_q + IW'(1);
              state_q <= S_PREP;
            end
          end
        end

        S_ADJ: begin
          for (int k = 0; k < MAX_SIZE; k++) begin
            if (row_vis_q[k]) begin
              row_lbl_q[k] <= row_lbl_q[k] - LB'(mn_q);
            end
            if (col_vis_q[k]) begin
              col_lbl_q[k] <= col_lbl_q[k] + LB'(mn_q);
            end
          end
          state_q <= S_PREP;
        end

        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_row_q   <= wbm_pkg::RowW'(ir_q);
            out_col_q   <= row_ptr_v_q[ir_q] ? wbm_pkg::RowW'(row_ptr_q[ir_q]) : '0;
            out_last_q  <= (ir_q == n_m1);
            if (ir_q == n_m1) begin
              state_q <= S_LOAD;
            end else begin
              ir_q <= ir_q + IW'(1);
            end
          end
        end

        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign row_index_o      = out_row_q;
  assign matched_column_o = out_col_q;
  assign last_o           = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/wbm_checker.sv
// ----------------------------------------------------------------------------
// wbm_checker
// Port-level checks of the weighted bipartite matcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module wbm_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_ready_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [wbm_pkg::RowW-1:0] row_index_o,
  input wire logic [wbm_pkg::RowW-1:0] matched_column_o,
  input wire logic                     last_o,
  input wire logic                     pready
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o) &&
      $stable(matched_column_o) && $stable(last_o))
    else $error("result changed while stalled");

  // No weight transfer while a row other than the last is still on its way out.
  a_no_load_mid_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open during result emission");

  // Rows stream back to back once the first is taken.
  a_rows_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap between result rows");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind weighted_bipartite_matcher wbm_checker u_wbm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .row_index_o     (row_index_o),
  .matched_column_o(matched_column_o),
  .last_o          (last_o),
  .pready          (pready)
);

`default_nettype wire
